@@ rtl/core/reconnect_relay_generation_router_assert.svh @@
// Assertion macros shared by the relay generation router files.
`ifndef RECONNECT_RELAY_GENERATION_ROUTER_ASSERT_SVH
`define RECONNECT_RELAY_GENERATION_ROUTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RRGR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRGR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rrgr_pkg.sv @@
// Package: event codes, route codes and beat structs for the relay generation router.
package rrgr_pkg;

    typedef enum logic [2:0] {
        MODE_PREPARE_RETIRE   = 3'd0,
        MODE_CONFIRM_SHUTDOWN = 3'd1,
        MODE_BEGIN_RELEARN    = 3'd2,
        MODE_CLIENT_DGRAM     = 3'd3,
        MODE_SERVER_DGRAM     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ROUTE_REJECT = 2'd0,
        ROUTE_A      = 2'd1,
        ROUTE_B      = 2'd2
    } route_t;

    typedef struct packed {
        mode_t mode;
        logic  old_transport_done;
        logic  held_queue_empty;
        logic  shutdown_seen;
        logic  process_gone;
        logic  old_source_quiet;
        logic  source_ok;
        logic  is_connectionless;
        logic  carries_connect;
        logic  carries_accept;
    } rrgr_item_t;

    typedef struct packed {
        logic   accepted;
        route_t route;
    } rrgr_result_t;

endpackage

@@ rtl/core/reconnect_relay_generation_router.sv @@
// Top level of the relay generation router: input register, decision core, result register.
// One beat in, one beat out, one beat per cycle sustained while out_stall is low. An
// accepted event is held in the input register and is decided there combinationally
// against the hand-over flags and the A-tail counter (flags and counter update as the
// beat moves on); its result is registered into the result register as it moves on
// and is shown from there. The result register is the only thing that holds a
// finished result, so a stalled result holds back the input register; while both
// registers are full, in_stall follows out_stall in the same cycle. Modes 5 to 7 are
// answered with accepted 0 and route 0 and change nothing.
// The A-tail counter saturates at all ones; a sequenced A-tail datagram that finds it full
// is rejected.
module reconnect_relay_generation_router #(
    parameter int TAIL_COUNT_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // event channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic       old_transport_done,
    input  logic       held_queue_empty,
    input  logic       shutdown_seen,
    input  logic       process_gone,
    input  logic       old_source_quiet,
    input  logic       source_ok,
    input  logic       is_connectionless,
    input  logic       carries_connect,
    input  logic       carries_accept,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [1:0] route
);
    import rrgr_pkg::*;

    `include "reconnect_relay_generation_router_assert.svh"

    logic         in_valid_reg, in_valid_next;
    rrgr_item_t   in_item_reg;
    logic         out_valid_reg, out_valid_next;
    rrgr_result_t out_item_reg;
    rrgr_result_t core_result;
    rrgr_item_t   in_item;
    logic         in_take;
    logic         advance;

    // decide the held beat when the result slot is free or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_item.mode               = mode_t'(mode);
    assign in_item.old_transport_done = old_transport_done;
    assign in_item.held_queue_empty   = held_queue_empty;
    assign in_item.shutdown_seen      = shutdown_seen;
    assign in_item.process_gone       = process_gone;
    assign in_item.old_source_quiet   = old_source_quiet;
    assign in_item.source_ok          = source_ok;
    assign in_item.is_connectionless  = is_connectionless;
    assign in_item.carries_connect    = carries_connect;
    assign in_item.carries_accept     = carries_accept;

    rrgr_core #(
        .TAIL_COUNT_WIDTH (TAIL_COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_item_reg.accepted;
    assign route     = out_item_reg.route;

    `RRGR_ASSERT_IMPL(a_route_implies_acc,
                      out_valid_reg && (out_item_reg.route != ROUTE_REJECT),
                      out_item_reg.accepted, "routed beat not accepted")
    `RRGR_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && !advance, in_valid_reg,
                      "held event beat lost")
    `RRGR_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg,
                      "decided beat not shown")

endmodule

@@ rtl/core/rrgr_core.sv @@
// Hand-over state flags, A-tail counter and per-event decision logic.
module rrgr_core #(
    parameter int TAIL_COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  rrgr_pkg::rrgr_item_t item,
    output rrgr_pkg::rrgr_result_t result
);
    import rrgr_pkg::*;

    `include "reconnect_relay_generation_router_assert.svh"

    logic retire_prepared_reg, retire_prepared_next;
    logic shutdown_confirmed_reg, shutdown_confirmed_next;
    logic relearn_ready_reg, relearn_ready_next;
    logic endpoint_learned_reg, endpoint_learned_next;
    logic connect_logged_reg, connect_logged_next;
    logic accept_logged_reg, accept_logged_next;
    logic [TAIL_COUNT_WIDTH-1:0] tail_count_reg, tail_count_next;

    logic any_b;
    logic tail_full;
    logic tail_zero;
    logic ok;
    route_t route_sel;

    assign any_b     = relearn_ready_reg | endpoint_learned_reg |
                       connect_logged_reg | accept_logged_reg;
    assign tail_full = (tail_count_reg == {TAIL_COUNT_WIDTH{1'b1}});
    assign tail_zero = (tail_count_reg == '0);

    always_comb
    begin
        retire_prepared_next    = retire_prepared_reg;
        shutdown_confirmed_next = shutdown_confirmed_reg;
        relearn_ready_next      = relearn_ready_reg;
        endpoint_learned_next   = endpoint_learned_reg;
        connect_logged_next     = connect_logged_reg;
        accept_logged_next      = accept_logged_reg;
        tail_count_next         = tail_count_reg;
        ok                      = 1'b0;
        route_sel               = ROUTE_REJECT;

        unique case (item.mode)
            MODE_PREPARE_RETIRE:
            begin
                if (!retire_prepared_reg && !shutdown_confirmed_reg && !any_b && tail_zero &&
                    item.old_transport_done && item.held_queue_empty)
                begin
                    retire_prepared_next = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_CONFIRM_SHUTDOWN:
            begin
                if (retire_prepared_reg && !shutdown_confirmed_reg && !any_b &&
                    item.shutdown_seen && item.process_gone)
                begin
                    shutdown_confirmed_next = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_BEGIN_RELEARN:
            begin
                if (!any_b && item.old_transport_done && item.old_source_quiet &&
                    item.held_queue_empty && retire_prepared_reg && shutdown_confirmed_reg)
                begin
                    relearn_ready_next = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_CLIENT_DGRAM:
            begin
                // endpoint learn sticks even if the rest of the checks refuse the beat
                if (relearn_ready_reg && item.source_ok &&
                    (endpoint_learned_reg || item.is_connectionless))
                begin
                    endpoint_learned_next = 1'b1;
                    if (accept_logged_reg || item.is_connectionless)
                    begin
                        if (!item.carries_connect)
                        begin
                            ok = 1'b1;
                        end
                        else if (item.is_connectionless && !accept_logged_reg)
                        begin
                            connect_logged_next = 1'b1;
                            ok = 1'b1;
                        end
                    end
                end
            end
            MODE_SERVER_DGRAM:
            begin
                if (shutdown_confirmed_reg && item.source_ok)
                begin
                    if (!relearn_ready_reg || !endpoint_learned_reg)
                    begin
                        if (item.is_connectionless)
                        begin
                            route_sel = ROUTE_A;
                        end
                        else if (!tail_full)
                        begin
                            tail_count_next = tail_count_reg + 1'b1;
                            route_sel = ROUTE_A;
                        end
                    end
                    else if (item.is_connectionless)
                    begin
                        if (!item.carries_accept)
                        begin
                            route_sel = ROUTE_B;
                        end
                        else if (connect_logged_reg && !accept_logged_reg)
                        begin
                            accept_logged_next = 1'b1;
                            route_sel = ROUTE_B;
                        end
                    end
                    else if (accept_logged_reg)
                    begin
                        route_sel = ROUTE_B;
                    end
                    else if (!tail_full)
                    begin
                        // sequenced A tail still draining
                        tail_count_next = tail_count_reg + 1'b1;
                        route_sel = ROUTE_A;
                    end
                end
                ok = (route_sel != ROUTE_REJECT);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign result.accepted = ok;
    assign result.route    = route_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retire_prepared_reg    <= 1'b0;
            shutdown_confirmed_reg <= 1'b0;
            relearn_ready_reg      <= 1'b0;
            endpoint_learned_reg   <= 1'b0;
            connect_logged_reg     <= 1'b0;
            accept_logged_reg      <= 1'b0;
            tail_count_reg         <= '0;
        end
        else if (step)
        begin
            retire_prepared_reg    <= retire_prepared_next;
            shutdown_confirmed_reg <= shutdown_confirmed_next;
            relearn_ready_reg      <= relearn_ready_next;
            endpoint_learned_reg   <= endpoint_learned_next;
            connect_logged_reg     <= connect_logged_next;
            accept_logged_reg      <= accept_logged_next;
            tail_count_reg         <= tail_count_next;
        end
    end

    `RRGR_ASSERT_IMPL(a_sd_needs_retire, shutdown_confirmed_reg, retire_prepared_reg,
                      "shutdown confirmed without retire")
    `RRGR_ASSERT_IMPL(a_learn_needs_relearn, endpoint_learned_reg, relearn_ready_reg,
                      "endpoint learned before relearn")
    `RRGR_ASSERT_IMPL(a_conn_needs_learn, connect_logged_reg, endpoint_learned_reg,
                      "connect logged before endpoint learned")
    `RRGR_ASSERT_IMPL(a_acc_needs_conn, accept_logged_reg, connect_logged_reg,
                      "accept logged before connect")
    `RRGR_ASSERT_NEXT(a_tail_idle, !step, $stable(tail_count_reg),
                      "tail counter moved without a beat")

endmodule
